// File: rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, disabled while reset is high.
`define HCMB_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// Concurrent assertion that also holds through reset.
`define HCMB_ASSERT_NR(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

// File: rtl/hcmb_pkg.sv
// Types and constants shared by the memory bus modules.
package hcmb_pkg;

  localparam int MEM_DEPTH = 65536;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);

  // Request commands
  localparam logic [2:0] CMD_READ  = 3'd0;
  localparam logic [2:0] CMD_WRITE = 3'd1;
  localparam logic [2:0] CMD_TILE  = 3'd2;
  localparam logic [2:0] CMD_LCD   = 3'd3;
  localparam logic [2:0] CMD_IRQ   = 3'd4;

  // Operation kinds passed from front to back
  localparam logic [2:0] OP_CONST  = 3'd0;
  localparam logic [2:0] OP_READ   = 3'd1;
  localparam logic [2:0] OP_WRITE  = 3'd2;
  localparam logic [2:0] OP_SERIAL = 3'd3;
  localparam logic [2:0] OP_DMA    = 3'd4;
  localparam logic [2:0] OP_TILE   = 3'd5;
  localparam logic [2:0] OP_LCD    = 3'd6;
  localparam logic [2:0] OP_IRQ    = 3'd7;

  // Special addresses
  localparam logic [15:0] ADDR_JOYP     = 16'hFF00;
  localparam logic [15:0] ADDR_SB       = 16'hFF01;
  localparam logic [15:0] ADDR_SC       = 16'hFF02;
  localparam logic [15:0] ADDR_DIV      = 16'hFF04;
  localparam logic [15:0] ADDR_IF       = 16'hFF0F;
  localparam logic [15:0] ADDR_LCDC     = 16'hFF40;
  localparam logic [15:0] ADDR_STAT     = 16'hFF41;
  localparam logic [15:0] ADDR_DMA      = 16'hFF46;
  localparam logic [15:0] ADDR_ROM_TOP  = 16'h7FFF;
  localparam logic [7:0]  OAM_PAGE      = 8'hFE;
  localparam logic [15:0] MAP_HI_BASE   = 16'h9C00;
  localparam logic [15:0] MAP_LO_BASE   = 16'h9800;
  localparam logic [15:0] TILE_U_BASE   = 16'h8000;
  localparam logic [15:0] TILE_S_BASE   = 16'h9000;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] addr;
    logic [7:0]  data;
  } op_t;

  typedef struct packed {
    logic [7:0]  rdata;
    logic [15:0] tile_address;
    logic        serial_valid;
    logic [7:0]  serial_char;
  } res_t;

endpackage

// File: rtl/hcmb_ram.sv
// Generic single write port, single read port RAM with registered read.
module hcmb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         q
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      q <= mem[raddr];
    end
  end

endmodule

// File: rtl/hcmb_fifo.sv
// Small register queue used between the bus stages.
module hcmb_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= din;
    end
  end

endmodule

// File: rtl/hcmb_front.sv
// Front end: decode a bus request into a back-end operation.
module hcmb_front (
  input  logic [2:0]       cmd,
  input  logic [15:0]      addr,
  input  logic [7:0]       wdata,
  input  logic [7:0]       buttons,
  input  logic [7:0]       random_byte,
  input  logic [4:0]       tile_x,
  input  logic [4:0]       tile_y,
  input  logic [1:0]       lcd_mode,
  input  logic [2:0]       irq_bit,
  output hcmb_pkg::op_t    op
);

  logic       sel_btn;
  logic       sel_dir;
  logic [7:0] joyp;

  assign sel_btn = !wdata[5];
  assign sel_dir = !wdata[4];

  always_comb begin
    if (sel_btn && !sel_dir) begin
      joyp = wdata | {4'h0, buttons[7:4]};
    end else if (sel_dir && !sel_btn) begin
      joyp = wdata | {4'h0, buttons[3:0]};
    end else begin
      joyp = wdata | 8'h0F;
    end
  end

  always_comb begin
    op.kind = hcmb_pkg::OP_CONST;
    op.addr = addr;
    op.data = 8'h00;
    unique case (cmd)
      hcmb_pkg::CMD_READ: begin
        if (addr == hcmb_pkg::ADDR_DIV) begin
          op.data = random_byte;
        end else begin
          op.kind = hcmb_pkg::OP_READ;
        end
      end
      hcmb_pkg::CMD_WRITE: begin
        if (addr <= hcmb_pkg::ADDR_ROM_TOP) begin
          op.kind = hcmb_pkg::OP_CONST;
        end else if (addr == hcmb_pkg::ADDR_JOYP) begin
          op.kind = hcmb_pkg::OP_WRITE;
          op.data = joyp;
        end else if (addr == hcmb_pkg::ADDR_DIV) begin
          op.kind = hcmb_pkg::OP_WRITE;
        end else if (addr == hcmb_pkg::ADDR_DMA) begin
          op.kind = hcmb_pkg::OP_DMA;
          op.data = wdata;
        end else if (addr == hcmb_pkg::ADDR_SC) begin
          op.kind = hcmb_pkg::OP_SERIAL;
          op.data = wdata;
        end else begin
          op.kind = hcmb_pkg::OP_WRITE;
          op.data = wdata;
        end
      end
      hcmb_pkg::CMD_TILE: begin
        op.kind = hcmb_pkg::OP_TILE;
        op.addr = {6'b0, tile_y, tile_x};
      end
      hcmb_pkg::CMD_LCD: begin
        op.kind = hcmb_pkg::OP_LCD;
        op.data = {6'b0, lcd_mode};
      end
      hcmb_pkg::CMD_IRQ: begin
        op.kind = hcmb_pkg::OP_IRQ;
        op.data = {5'b0, irq_bit};
      end
      default: begin
        op.kind = hcmb_pkg::OP_CONST;
      end
    endcase
  end

endmodule

// File: rtl/hcmb_back.sv
// Back end: execute operations against the bus memory and build results.
module hcmb_back #(
  parameter int DMA_LENGTH = 159
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             op_empty,
  input  hcmb_pkg::op_t    op,
  output logic             op_pop,
  input  logic             res_full,
  output logic             res_push,
  output hcmb_pkg::res_t   res,
  output logic             clearing
);

  localparam int CNT_W = (DMA_LENGTH > 1) ? $clog2(DMA_LENGTH) : 1;

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_RDWAIT = 3'd2;
  localparam logic [2:0] S_DMA_RD = 3'd3;
  localparam logic [2:0] S_DMA_WR = 3'd4;

  logic [2:0]                  state;
  logic [2:0]                  state_next;
  logic [hcmb_pkg::ADDR_W-1:0] clr_addr;
  logic [CNT_W-1:0]            cnt;
  logic [7:0]                  page;
  logic                        tile_rd;
  logic [7:0]                  lcdc;
  logic [7:0]                  stat;
  logic [7:0]                  iflag;
  logic [7:0]                  sb;

  logic                        we;
  logic [hcmb_pkg::ADDR_W-1:0] waddr;
  logic [7:0]                  wdat;
  logic                        re;
  logic [hcmb_pkg::ADDR_W-1:0] raddr;
  logic [7:0]                  q;
  logic                        go;
  logic                        dma_last;

  assign clearing = (state == S_CLEAR);
  assign go       = !op_empty && !res_full;
  assign dma_last = (cnt == CNT_W'(DMA_LENGTH - 1));

  hcmb_ram #(
    .WIDTH(8),
    .DEPTH(hcmb_pkg::MEM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdat),
    .re    (re),
    .raddr (raddr),
    .q     (q)
  );

  always_comb begin
    state_next = state;
    op_pop     = 1'b0;
    res_push   = 1'b0;
    res        = '0;
    we         = 1'b0;
    waddr      = op.addr;
    wdat       = op.data;
    re         = 1'b0;
    raddr      = op.addr;
    unique case (state)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = clr_addr;
        wdat  = 8'h00;
        if (clr_addr == '1) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (go) begin
          op_pop = 1'b1;
          unique case (op.kind)
            hcmb_pkg::OP_CONST: begin
              res_push  = 1'b1;
              res.rdata = op.data;
            end
            hcmb_pkg::OP_READ: begin
              re         = 1'b1;
              state_next = S_RDWAIT;
            end
            hcmb_pkg::OP_TILE: begin
              re         = 1'b1;
              raddr      = (lcdc[3] ? hcmb_pkg::MAP_HI_BASE : hcmb_pkg::MAP_LO_BASE)
                           + {6'b0, op.addr[9:0]};
              state_next = S_RDWAIT;
            end
            hcmb_pkg::OP_WRITE: begin
              we       = 1'b1;
              res_push = 1'b1;
            end
            hcmb_pkg::OP_SERIAL: begin
              we               = 1'b1;
              res_push         = 1'b1;
              res.serial_valid = 1'b1;
              res.serial_char  = sb;
            end
            hcmb_pkg::OP_LCD: begin
              we       = 1'b1;
              waddr    = hcmb_pkg::ADDR_STAT;
              wdat     = {stat[7:2], op.data[1:0]};
              res_push = 1'b1;
            end
            hcmb_pkg::OP_IRQ: begin
              we       = 1'b1;
              waddr    = hcmb_pkg::ADDR_IF;
              wdat     = iflag | (8'h01 << op.data[2:0]);
              res_push = 1'b1;
            end
            hcmb_pkg::OP_DMA: begin
              state_next = S_DMA_RD;
            end
            default: begin
              res_push = 1'b1;
            end
          endcase
        end
      end
      S_RDWAIT: begin
        res_push = 1'b1;
        if (tile_rd) begin
          res.tile_address = lcdc[4]
            ? hcmb_pkg::TILE_U_BASE + {4'h0, q, 4'h0}
            : hcmb_pkg::TILE_S_BASE + {{4{q[7]}}, q, 4'h0};
        end else begin
          res.rdata = q;
        end
        state_next = S_IDLE;
      end
      S_DMA_RD: begin
        re         = 1'b1;
        raddr      = {page, 8'(cnt)};
        state_next = S_DMA_WR;
      end
      S_DMA_WR: begin
        we    = 1'b1;
        waddr = {hcmb_pkg::OAM_PAGE, 8'(cnt)};
        wdat  = q;
        if (dma_last) begin
          res_push   = 1'b1;
          state_next = S_IDLE;
        end else begin
          state_next = S_DMA_RD;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      cnt      <= '0;
      lcdc     <= 8'h00;
      stat     <= 8'h00;
      iflag    <= 8'h00;
      sb       <= 8'h00;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (state == S_IDLE) begin
        cnt <= '0;
      end else if (state == S_DMA_WR) begin
        cnt <= cnt + 1'b1;
      end
      // Mirror the registers the back end reads without a memory access
      if (we) begin
        unique case (waddr)
          hcmb_pkg::ADDR_LCDC: lcdc  <= wdat;
          hcmb_pkg::ADDR_STAT: stat  <= wdat;
          hcmb_pkg::ADDR_IF:   iflag <= wdat;
          hcmb_pkg::ADDR_SB:   sb    <= wdat;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && go) begin
      page    <= op.data;
      tile_rd <= (op.kind == hcmb_pkg::OP_TILE);
    end
  end

endmodule

// File: rtl/handheld_console_memory_bus.sv
// Top level of the handheld console memory bus.
// Usage:
//   Requests enter through a queue-like port: drive cmd and the payload
//   fields with push; the request is taken on a clock edge where push is
//   high and full is low. Every request yields exactly one result.
//   Results leave through a queue-like port: while empty is low the oldest
//   result sits on rdata, tile_address, serial_valid and serial_char; pop
//   takes it on an edge where empty is low.
//   Requests are decoded on entry and held in a four-entry request queue;
//   the execution unit works through them one at a time against a 64K-byte
//   single-port-write, registered-read memory.
//   Execution: writes, constant reads and mode/interrupt updates push
//   their result when popped; memory reads and tile lookups push it from
//   a read-wait state after the registered read; an OAM DMA alternates
//   read and write states per byte and pushes its result after the last
//   write. Writes take one request per cycle while the result queue has
//   room; reads, tile lookups and DMA hold the unit until it is pushed.
//   Reset: the memory is cleared to zero address by address; full stays
//   high until it completes. Both queues are emptied.
//   Stall: when the two-entry result queue is full the execution unit holds,
//   the request queue fills and full rises.
module handheld_console_memory_bus #(
  parameter int DMA_LENGTH = 159
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  cmd,
  input  logic [15:0] addr,
  input  logic [7:0]  wdata,
  input  logic [7:0]  buttons,
  input  logic [7:0]  random_byte,
  input  logic [4:0]  tile_x,
  input  logic [4:0]  tile_y,
  input  logic [1:0]  lcd_mode,
  input  logic [2:0]  irq_bit,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  rdata,
  output logic [15:0] tile_address,
  output logic        serial_valid,
  output logic [7:0]  serial_char
);

  hcmb_pkg::op_t  dec_op;
  hcmb_pkg::op_t  q_op;
  hcmb_pkg::res_t res_in;
  hcmb_pkg::res_t res_out;
  logic           op_full;
  logic           op_empty;
  logic           op_pop;
  logic           res_full;
  logic           res_push;
  logic           clearing;

  assign full = op_full || clearing;

  hcmb_front u_front (
    .cmd         (cmd),
    .addr        (addr),
    .wdata       (wdata),
    .buttons     (buttons),
    .random_byte (random_byte),
    .tile_x      (tile_x),
    .tile_y      (tile_y),
    .lcd_mode    (lcd_mode),
    .irq_bit     (irq_bit),
    .op          (dec_op)
  );

  hcmb_fifo #(
    .WIDTH($bits(hcmb_pkg::op_t)),
    .DEPTH(4)
  ) u_op_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push && !clearing),
    .din   (dec_op),
    .full  (op_full),
    .pop   (op_pop),
    .dout  (q_op),
    .empty (op_empty)
  );

  hcmb_back #(
    .DMA_LENGTH(DMA_LENGTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .op_empty (op_empty),
    .op       (q_op),
    .op_pop   (op_pop),
    .res_full (res_full),
    .res_push (res_push),
    .res      (res_in),
    .clearing (clearing)
  );

  hcmb_fifo #(
    .WIDTH($bits(hcmb_pkg::res_t)),
    .DEPTH(2)
  ) u_res_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .din   (res_in),
    .full  (res_full),
    .pop   (pop),
    .dout  (res_out),
    .empty (empty)
  );

  assign rdata        = res_out.rdata;
  assign tile_address = res_out.tile_address;
  assign serial_valid = res_out.serial_valid;
  assign serial_char  = res_out.serial_char;

endmodule

// File: rtl/hcmb_checker.sv
// Port-level checker for the memory bus, bound to the top level.
`include "assert_macros.svh"

module hcmb_checker (
  input logic        clk,
  input logic        rst,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic [7:0]  rdata,
  input logic [15:0] tile_address,
  input logic        serial_valid,
  input logic [7:0]  serial_char
);

  `HCMB_ASSERT_NR(a_reset_full, clk, rst |=> full)
  `HCMB_ASSERT_NR(a_reset_empty, clk, rst |=> empty)
  `HCMB_ASSERT(a_serial_alone, clk, rst, (!empty && serial_valid) |-> ({rdata, tile_address} == '0))
  `HCMB_ASSERT(a_char_zero, clk, rst, (!empty && !serial_valid) |-> (serial_char == 8'h00))
  `HCMB_ASSERT(a_result_held, clk, rst, (!empty && !pop) |=> !empty)

endmodule

bind handheld_console_memory_bus hcmb_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .full         (full),
  .empty        (empty),
  .pop          (pop),
  .rdata        (rdata),
  .tile_address (tile_address),
  .serial_valid (serial_valid),
  .serial_char  (serial_char)
);
